### hdl/brf_pkg.sv
// Package for the byte ring FIFO: opcodes, controller states, result metadata.
// Used by every other file of the block except brf_ram; depends on nothing.
`default_nettype none

package brf_pkg;

    localparam int BYTE_W         = 8;
    localparam int COUNT_W        = 13;
    localparam int REQ_W          = 7;
    localparam int CFG_W          = 4;
    localparam int MAX_REQUEST    = 64;
    localparam int CAP_LOG2_RESET = 12;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [REQ_W-1:0]   t_req;
    typedef logic [CFG_W-1:0]   t_cfg;

    localparam t_count COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } t_opcode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    // Everything a result carries apart from the byte itself
    typedef struct packed {
        logic   byte_valid;
        t_count transfer_count;
        t_count fill_level;
        logic   is_empty;
        logic   is_full;
        logic   result_last;
    } t_meta;

    // One result launched by the controller into the output pipeline
    typedef struct packed {
        logic  load;
        logic  from_ram;
        t_meta meta;
    } t_issue;

endpackage

`default_nettype wire

### hdl/brf_if.sv
// Valid/ready channel interfaces for requests and results of the byte ring FIFO.
// Depends on brf_pkg for field widths.
`default_nettype none

interface brf_req_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           opcode;
    brf_pkg::t_byte       data_byte;
    logic                 burst_last;
    brf_pkg::t_req        request_length;

    modport source (output valid, opcode, data_byte, burst_last, request_length,
                    input ready);
    modport sink   (input valid, opcode, data_byte, burst_last, request_length,
                    output ready);
endinterface

interface brf_res_if;
    logic                 valid;
    logic                 ready;
    brf_pkg::t_byte       out_byte;
    logic                 byte_valid;
    brf_pkg::t_count      transfer_count;
    brf_pkg::t_count      fill_level;
    logic                 is_empty;
    logic                 is_full;
    logic                 result_last;

    modport source (output valid, out_byte, byte_valid, transfer_count, fill_level,
                    is_empty, is_full, result_last, input ready);
    modport sink   (input valid, out_byte, byte_valid, transfer_count, fill_level,
                    is_empty, is_full, result_last, output ready);
endinterface

`default_nettype wire

### hdl/brf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; read data holds while no read is enabled.
`default_nettype none

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held when idle
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/brf_ctrl.sv
// Ring FIFO controller: indices, burst counter, capacity and the read sequencer.
// Drives the store RAM and launches results into brf_out; uses brf_pkg.
`default_nettype none

module brf_ctrl #(
    parameter int DEPTH_LOG2 = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    brf_req_if.sink                    i_req,
    input  wire logic                  i_cfg_we,
    input  wire brf_pkg::t_cfg         i_cfg_wdata,
    input  wire logic                  i_slot_free,
    output brf_pkg::t_issue            o_issue,
    output logic                       o_ram_we,
    output logic [DEPTH_LOG2-1:0]      o_ram_waddr,
    output brf_pkg::t_byte             o_ram_wdata,
    output logic                       o_ram_re,
    output logic [DEPTH_LOG2-1:0]      o_ram_raddr
);
    import brf_pkg::*;

    localparam int AW       = DEPTH_LOG2;
    localparam int IW       = DEPTH_LOG2 + 1;
    localparam int LG_W     = $clog2(DEPTH_LOG2 + 1);
    localparam int RESET_LG = (CAP_LOG2_RESET > DEPTH_LOG2) ? DEPTH_LOG2 : CAP_LOG2_RESET;

    t_state            r_state, n_state;
    logic [IW-1:0]     r_wi, n_wi;
    logic [IW-1:0]     r_ri, n_ri;
    t_count            r_burst, n_burst;
    logic [LG_W-1:0]   r_lg, n_lg;
    logic [IW-1:0]     r_rd_ptr, n_rd_ptr;
    t_req              r_left, n_left;
    t_req              r_req_n, n_req_n;

    logic              accept;
    t_opcode           op;
    logic [IW-1:0]     reg_fill;
    logic [IW-1:0]     cap;
    logic [AW-1:0]     addr_mask;
    t_req              req_cl;
    t_req              fill_cl;
    t_req              take;
    logic [IW-1:0]     st_fill;
    t_count            burst_inc;

    assign op        = t_opcode'(i_req.opcode);
    assign accept    = i_req.valid && i_req.ready;
    assign reg_fill  = r_wi - r_ri;
    assign cap       = IW'(1) << r_lg;
    assign addr_mask = (AW'(1) << r_lg) - AW'(1);
    assign burst_inc = (r_burst != COUNT_MAX) ? r_burst + t_count'(1) : r_burst;

    // Bytes a read or peek returns: the request, at most 64, at most the fill
    always_comb begin
        req_cl  = (int'(i_req.request_length) > MAX_REQUEST) ?
                  REQ_W'(MAX_REQUEST) : i_req.request_length;
        fill_cl = (int'(reg_fill) > MAX_REQUEST) ? REQ_W'(MAX_REQUEST) : REQ_W'(reg_fill);
        take    = (fill_cl < req_cl) ? fill_cl : req_cl;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_cfg_we && accept && (op inside {OP_READ, OP_PEEK}) && take != '0) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (i_slot_free && r_left == REQ_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        i_req.ready = (r_state == ST_IDLE) && i_slot_free;
    end

    // Index update, store access and result launch
    always_comb begin
        n_wi        = r_wi;
        n_ri        = r_ri;
        n_burst     = r_burst;
        n_lg        = r_lg;
        n_rd_ptr    = r_rd_ptr;
        n_left      = r_left;
        n_req_n     = r_req_n;
        o_issue     = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_wi[AW-1:0] & addr_mask;
        o_ram_wdata = i_req.data_byte;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_rd_ptr[AW-1:0] & addr_mask;

        if (i_cfg_we) begin
            // New capacity empties the buffer
            if (i_cfg_wdata == '0) begin
                n_lg = LG_W'(1);
            end else if (int'(i_cfg_wdata) > DEPTH_LOG2) begin
                n_lg = LG_W'(DEPTH_LOG2);
            end else begin
                n_lg = LG_W'(i_cfg_wdata);
            end
            n_wi    = '0;
            n_ri    = '0;
            n_burst = '0;
        end else if (accept) begin
            o_issue.load             = 1'b1;
            o_issue.meta.result_last = 1'b1;
            case (op)
                OP_WRITE: begin
                    // Drop the byte when full
                    if (reg_fill < cap) begin
                        o_ram_we = 1'b1;
                        n_wi     = r_wi + IW'(1);
                        n_burst  = burst_inc;
                    end
                    if (i_req.burst_last) begin
                        o_issue.meta.transfer_count = n_burst;
                        n_burst                     = '0;
                    end
                end
                OP_READ, OP_PEEK: begin
                    // Non-empty request: hand over to the sequencer
                    if (take != '0) begin
                        o_issue.load = 1'b0;
                        n_rd_ptr     = r_ri;
                        n_left       = take;
                        n_req_n      = take;
                        if (op == OP_READ) begin
                            n_ri = r_ri + IW'(take);
                        end
                    end
                end
                OP_CLEAR: begin
                    n_wi    = '0;
                    n_ri    = '0;
                    n_burst = '0;
                end
                default: o_issue.load = 1'b1;
            endcase
        end else if (r_state == ST_READ && i_slot_free) begin
            // One store read per returned byte
            o_ram_re                 = 1'b1;
            o_issue.load             = 1'b1;
            o_issue.from_ram         = 1'b1;
            o_issue.meta.byte_valid  = 1'b1;
            o_issue.meta.result_last = (r_left == REQ_W'(1));
            if (r_left == REQ_W'(1)) begin
                o_issue.meta.transfer_count = t_count'(r_req_n);
            end
            n_rd_ptr = r_rd_ptr + IW'(1);
            n_left   = r_left - REQ_W'(1);
        end

        // Status after the step
        st_fill                 = n_wi - n_ri;
        o_issue.meta.fill_level = t_count'(st_fill);
        o_issue.meta.is_empty   = (st_fill == '0);
        o_issue.meta.is_full    = (st_fill == cap);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wi     <= '0;
            r_ri     <= '0;
            r_burst  <= '0;
            r_lg     <= LG_W'(RESET_LG);
            r_rd_ptr <= '0;
            r_left   <= '0;
            r_req_n  <= '0;
        end else begin
            r_state  <= n_state;
            r_wi     <= n_wi;
            r_ri     <= n_ri;
            r_burst  <= n_burst;
            r_lg     <= n_lg;
            r_rd_ptr <= n_rd_ptr;
            r_left   <= n_left;
            r_req_n  <= n_req_n;
        end
    end

`ifndef SYNTHESIS
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        reg_fill <= cap)
        else $error("fill level above capacity");

    a_read_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_left != '0))
        else $error("read sequencer active with nothing left");

    a_read_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && i_slot_free && r_left == REQ_W'(1)) |=> (r_state == ST_IDLE))
        else $error("read sequencer did not return to idle");

    a_no_write_during_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_re |-> !o_ram_we)
        else $error("store written while a request is being read out");
`endif

endmodule

`default_nettype wire

### hdl/brf_out.sv
// Output pipeline: a stage aligned with the RAM read latency, then the result register.
// Takes launches from brf_ctrl and read data from brf_ram; uses brf_pkg.
`default_nettype none

module brf_out (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire brf_pkg::t_issue   i_issue,
    input  wire brf_pkg::t_byte    i_ram_rdata,
    output logic                   o_slot_free,
    brf_res_if.source              o_res
);
    import brf_pkg::*;

    logic   r_p_valid;
    logic   r_p_ram;
    t_meta  r_p_meta;
    logic   r_o_valid;
    t_meta  r_o_meta;
    t_byte  r_o_byte;
    logic   p_move;

    // Advance the aligned stage when the result register is free or drains
    assign p_move      = r_p_valid && (!r_o_valid || o_res.ready);
    assign o_slot_free = !r_p_valid || p_move;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_issue.load) begin
                r_p_valid <= 1'b1;
            end else if (p_move) begin
                r_p_valid <= 1'b0;
            end
            if (p_move) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload: RAM data lines up with the aligned stage
    always_ff @(posedge i_clk) begin
        if (i_issue.load) begin
            r_p_ram  <= i_issue.from_ram;
            r_p_meta <= i_issue.meta;
        end
        if (p_move) begin
            r_o_meta <= r_p_meta;
            r_o_byte <= r_p_ram ? i_ram_rdata : '0;
        end
    end

    assign o_res.valid          = r_o_valid;
    assign o_res.out_byte       = r_o_byte;
    assign o_res.byte_valid     = r_o_meta.byte_valid;
    assign o_res.transfer_count = r_o_meta.transfer_count;
    assign o_res.fill_level     = r_o_meta.fill_level;
    assign o_res.is_empty       = r_o_meta.is_empty;
    assign o_res.is_full        = r_o_meta.is_full;
    assign o_res.result_last    = r_o_meta.result_last;

`ifndef SYNTHESIS
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && !p_move) |-> !i_issue.load)
        else $error("launch into an occupied stage");

    a_move_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p_move |=> r_o_valid)
        else $error("advanced result lost");

    a_ram_byte_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> (r_p_ram == r_p_meta.byte_valid))
        else $error("byte flag disagrees with data source");
`endif

endmodule

`default_nettype wire

### hdl/byte_ring_fifo_burst.sv
// Top level of the byte ring FIFO: controller, output pipeline and byte store RAM.
// Depends on brf_pkg, brf_if, brf_ram, brf_ctrl and brf_out.
`default_nettype none

// Byte FIFO on a ring store of 2^DEPTH_LOG2 bytes, of which 2^capacity_log2
// are in use (the register is clamped to 1..DEPTH_LOG2; writing it empties
// the buffer). Requests arrive on i_req, results leave on o_res, both
// valid/ready. A write, a clear, or a read/peek that finds nothing to return
// gives one result; the next request may follow while that result waits on
// o_res. A read or peek returning n bytes (n up to 64) first takes the
// request, then returns one byte per cycle while o_res does not stall, a rate
// set by the single read port of the store RAM. Bytes written while full are
// dropped; the last byte of a burst reports how many of its bytes were kept.
// Every result carries the fill level after the request, with empty and full
// flags.
module byte_ring_fifo_burst #(
    parameter int DEPTH_LOG2 = 12
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    brf_req_if.sink             i_req,
    brf_res_if.source           o_res,
    input  wire logic           i_cfg_we,
    input  wire brf_pkg::t_cfg  i_cfg_wdata
);
    import brf_pkg::*;

    localparam int DEPTH = 1 << DEPTH_LOG2;

    t_issue                issue;
    logic                  slot_free;
    logic                  ram_we;
    logic [DEPTH_LOG2-1:0] ram_waddr;
    t_byte                 ram_wdata;
    logic                  ram_re;
    logic [DEPTH_LOG2-1:0] ram_raddr;
    t_byte                 ram_rdata;

    brf_ctrl #(
        .DEPTH_LOG2 (DEPTH_LOG2)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_slot_free (slot_free),
        .o_issue     (issue),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr)
    );

    brf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    brf_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_ram_rdata (ram_rdata),
        .o_slot_free (slot_free),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

### dv/tb_byte_ring_fifo_burst.sv
`timescale 1ns / 1ps
// Testbench for byte_ring_fifo_burst: directed and random request streams, each result
// checked against a scoreboard that mirrors the ring store.
// Depends on brf_pkg, the brf_req_if/brf_res_if interfaces and the block's RTL.

module tb_byte_ring_fifo_burst;
    import brf_pkg::*;

    localparam int DEPTH_LOG2  = 12;
    localparam int RING_SIZE   = 1 << DEPTH_LOG2;
    localparam int TAIL_CYCLES = 80;

    typedef struct packed {
        t_byte  out_byte;
        logic   byte_valid;
        t_count transfer_count;
        t_count fill_level;
        logic   is_empty;
        logic   is_full;
        logic   result_last;
    } t_result;

    // Mirror of the ring: pointers, burst counter, capacity and pending results
    class brf_scoreboard;
        t_byte               ring [RING_SIZE];
        logic [DEPTH_LOG2:0] wr_ptr;
        logic [DEPTH_LOG2:0] rd_ptr;
        t_count              burst_kept;
        t_cfg                cap_log2;
        t_result             pending_results[$];
        int unsigned         mismatches;

        function new();
            cap_log2   = t_cfg'(CAP_LOG2_RESET);
            mismatches = 0;
            empty_ring();
        endfunction

        function void empty_ring();
            wr_ptr     = '0;
            rd_ptr     = '0;
            burst_kept = '0;
        endfunction

        function int unsigned capacity();
            int unsigned lg;
            lg = cap_log2;
            if (lg < 1) lg = 1;
            if (lg > DEPTH_LOG2) lg = DEPTH_LOG2;
            return 1 << lg;
        endfunction

        function int unsigned level();
            logic [DEPTH_LOG2:0] diff;
            diff = wr_ptr - rd_ptr;
            return diff;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void set_capacity(t_cfg value);
            cap_log2 = value;
            empty_ring();
        endfunction

        // Queue one result; flags reflect the state after the whole request
        function void push(t_byte b, logic valid, int unsigned count, logic last);
            t_result r;
            r.out_byte       = b;
            r.byte_valid     = valid;
            r.transfer_count = t_count'(count);
            r.fill_level     = t_count'(level());
            r.is_empty       = (level() == 0);
            r.is_full        = (level() == capacity());
            r.result_last    = last;
            pending_results.push_back(r);
        endfunction

        // Advance the mirror by one accepted request and queue its results
        function void note_request(t_opcode op, t_byte data, logic last, t_req len);
            int unsigned cap;
            int unsigned n;
            int unsigned start;
            int unsigned k;
            t_byte       taken [MAX_REQUEST];
            cap = capacity();
            case (op)
                OP_WRITE: begin
                    // drop the byte when full
                    if (level() < cap) begin
                        ring[int'(wr_ptr) & (cap - 1)] = data;
                        wr_ptr = wr_ptr + 1'b1;
                        if (burst_kept != COUNT_MAX) burst_kept = burst_kept + 1'b1;
                    end
                    if (last) begin
                        push('0, 1'b0, burst_kept, 1'b1);
                        burst_kept = '0;
                    end else begin
                        push('0, 1'b0, 0, 1'b1);
                    end
                end
                OP_CLEAR: begin
                    empty_ring();
                    push('0, 1'b0, 0, 1'b1);
                end
                default: begin
                    n = len;
                    if (n > MAX_REQUEST) n = MAX_REQUEST;
                    if (n > level()) n = level();
                    start = rd_ptr;
                    for (k = 0; k < n; k++) taken[k] = ring[(start + k) & (cap - 1)];
                    // peek leaves the read pointer where it was
                    if (op == OP_READ) rd_ptr = rd_ptr + n[DEPTH_LOG2:0];
                    if (n == 0) push('0, 1'b0, 0, 1'b1);
                    for (k = 0; k < n; k++) begin
                        push(taken[k], 1'b1, (k + 1 == n) ? n : 0, (k + 1 == n));
                    end
                end
            endcase
        endfunction

        function string show(t_result r);
            return $sformatf("byte=%0d valid=%0d count=%0d fill=%0d empty=%0d full=%0d last=%0d",
                             r.out_byte, r.byte_valid, r.transfer_count, r.fill_level,
                             r.is_empty, r.is_full, r.result_last);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result with none pending: expected nothing, got %s",
                         $time, show(got));
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                $display("%0t: result mismatch: expected %s, got %s",
                         $time, show(want), show(got));
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    t_cfg cfg_wdata;

    brf_req_if req_ch ();
    brf_res_if res_ch ();

    brf_scoreboard sb;
    int unsigned   burst_left;
    int unsigned   gap_max;

    byte_ring_fifo_burst #(
        .DEPTH_LOG2(DEPTH_LOG2)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up after a generous fixed time
    initial begin
        #8_000_000;
        $display("** byte_ring_fifo_burst: FAILED **");
        $finish;
    end

    // Take results, stalling on a rotating pattern that is redrawn now and then
    initial begin
        t_result     got;
        logic [7:0]  pattern;
        int unsigned hold;
        res_ch.ready <= 1'b0;
        pattern = 8'hFF;
        hold    = 0;
        forever begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready) begin
                got.out_byte       = res_ch.out_byte;
                got.byte_valid     = res_ch.byte_valid;
                got.transfer_count = res_ch.transfer_count;
                got.fill_level     = res_ch.fill_level;
                got.is_empty       = res_ch.is_empty;
                got.is_full        = res_ch.is_full;
                got.result_last    = res_ch.result_last;
                sb.check_result(got);
            end
            if (hold == 0) begin
                pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
                hold    = $urandom_range(16, 96);
            end
            hold--;
            pattern = {pattern[0], pattern[7:1]};
            res_ch.ready <= pattern[0];
        end
    end

    // Send one request; bursts of back-to-back requests are separated by gaps
    task automatic send_request(input t_opcode op, input t_byte data, input logic last,
                                input t_req len);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, (gap_max == 0) ? 1 : gap_max)) @(posedge clk);
            burst_left = (gap_max == 0) ? 100000 : $urandom_range(1, 12);
        end
        req_ch.valid          <= 1'b1;
        req_ch.opcode         <= op;
        req_ch.data_byte      <= data;
        req_ch.burst_last     <= last;
        req_ch.request_length <= len;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(op, data, last, len);
        burst_left--;
        if (burst_left == 0) req_ch.valid <= 1'b0;
    endtask

    // Hold off new requests until every pending result has arrived
    task automatic pause_until_drained();
        if (burst_left != 0) begin
            req_ch.valid <= 1'b0;
            burst_left = 0;
        end
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_capacity(input t_cfg value);
        pause_until_drained();
        repeat (4) @(posedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_capacity(value);
    endtask

    // Mostly well-formed bursts and reads, with broken bursts, noise and clears
    task automatic random_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned blen;
        int unsigned cap;
        int unsigned k;
        int unsigned roll;
        int unsigned pick;
        logic        broken;
        t_req        len;
        sent    = 0;
        gap_max = $urandom_range(0, 6);
        while (sent < n_items) begin
            cap  = sb.capacity();
            roll = $urandom_range(0, 19);
            if (roll <= 10) begin
                blen   = $urandom_range(1, (cap + 3 > 24) ? 24 : cap + 3);
                broken = ($urandom_range(0, 9) == 0);
                for (k = 0; k < blen; k++) begin
                    send_request(OP_WRITE, t_byte'($urandom), (k + 1 == blen) && !broken,
                                 t_req'($urandom));
                end
                sent += blen;
            end else if (roll <= 16) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) len = '0;
                else if (pick == 1) len = t_req'(MAX_REQUEST);
                else if (pick == 2) len = t_req'($urandom_range(65, 127));
                else len = t_req'($urandom_range(1, 20));
                send_request((roll <= 14) ? OP_READ : OP_PEEK, t_byte'($urandom),
                             1'($urandom), len);
                sent++;
            end else if (roll == 17) begin
                send_request(OP_CLEAR, t_byte'($urandom), 1'($urandom), t_req'($urandom));
                sent++;
            end else if (roll == 18) begin
                send_request(OP_WRITE, t_byte'($urandom), 1'($urandom), t_req'($urandom));
                sent++;
            end else begin
                pause_until_drained();
            end
        end
    endtask

    initial begin
        t_cfg phase_caps [8];
        int   p;
        sb = new();
        phase_caps = '{4'd1, 4'd0, 4'd3, 4'd15, 4'd2, 4'd5, 4'd8, 4'd7};
        phase_caps[7] = t_cfg'($urandom);
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.opcode         <= OP_WRITE;
        req_ch.data_byte      <= '0;
        req_ch.burst_last     <= 1'b0;
        req_ch.request_length <= '0;
        burst_left = 0;
        gap_max    = 3;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Empty reads, extreme bytes, clamped lengths and a clear at reset capacity
        send_request(OP_READ,  8'h00, 1'b0, 7'd5);
        send_request(OP_PEEK,  8'hFF, 1'b1, 7'd0);
        send_request(OP_WRITE, 8'h00, 1'b0, 7'd127);
        send_request(OP_WRITE, 8'hFF, 1'b0, 7'd0);
        send_request(OP_WRITE, 8'hA5, 1'b1, 7'd64);
        send_request(OP_PEEK,  8'h00, 1'b0, 7'd127);
        send_request(OP_READ,  8'hFF, 1'b1, 7'd2);
        send_request(OP_READ,  8'h00, 1'b0, 7'd64);
        send_request(OP_WRITE, 8'h5A, 1'b1, 7'd1);
        send_request(OP_CLEAR, 8'hFF, 1'b1, 7'd127);
        send_request(OP_READ,  8'h00, 1'b0, 7'd10);

        // Smallest ring: overflow drops, zero-count burst, full flag
        write_capacity(4'd1);
        send_request(OP_WRITE, 8'h11, 1'b0, 7'd0);
        send_request(OP_WRITE, 8'h22, 1'b0, 7'd0);
        send_request(OP_WRITE, 8'h33, 1'b0, 7'd0);
        send_request(OP_WRITE, 8'h44, 1'b1, 7'd0);
        send_request(OP_WRITE, 8'h55, 1'b1, 7'd0);
        send_request(OP_READ,  8'h00, 1'b0, 7'd0);
        send_request(OP_PEEK,  8'h00, 1'b0, 7'd64);
        send_request(OP_READ,  8'h00, 1'b0, 7'd64);
        send_request(OP_READ,  8'h00, 1'b0, 7'd64);

        // Largest ring: a short burst, a peek and a clamped read
        write_capacity(4'd12);
        gap_max = 2;
        repeat (9) send_request(OP_WRITE, t_byte'($urandom), 1'b0, t_req'($urandom));
        send_request(OP_WRITE, t_byte'($urandom), 1'b1, t_req'($urandom));
        send_request(OP_PEEK, t_byte'($urandom), 1'b0, 7'd64);
        send_request(OP_READ, t_byte'($urandom), 1'b0, 7'd127);

        // Random traffic over a spread of capacities, clamped values included
        for (p = 0; p < 8; p++) begin
            write_capacity(phase_caps[p]);
            random_phase(29);
        end

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("** byte_ring_fifo_burst: PASSED **");
        end else begin
            $display("** byte_ring_fifo_burst: FAILED **");
        end
        $finish;
    end

endmodule
